[hw/rtl/ned_pkg.sv]
// Shared types, constants and helper functions for the nearest edit distance match block.
// Depends on nothing; the interfaces, the top module and the testbench import it.
`default_nettype none

package ned_pkg;

  // Widths of the result fields and of a character.
  localparam int unsigned DistW  = 8;
  localparam int unsigned IndexW = 10;
  localparam int unsigned CharW  = 8;

  // Largest distance and largest index that the result fields can carry.
  localparam logic [DistW-1:0]  DistMax  = 8'd255;
  localparam int unsigned       IndexMax = 1023;

  // Upper case ASCII range and the offset to its lower case form.
  localparam logic [CharW-1:0] UpperFirst = 8'h41;
  localparam logic [CharW-1:0] UpperLast  = 8'h5A;
  localparam logic [CharW-1:0] CaseOffset = 8'h20;

  // Beat kinds on the input channel.
  typedef enum logic [1:0] {
    MODE_QUERY = 2'd0,
    MODE_CAND  = 2'd1,
    MODE_EMPTY = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_e;

  // Lower case folding for ASCII A to Z only.
  function automatic logic [CharW-1:0] fold_char(input logic [CharW-1:0] c);
    if ((c >= UpperFirst) && (c <= UpperLast)) begin
      return c + CaseOffset;
    end
    return c;
  endfunction

  // Increment that sticks at the largest distance.
  function automatic logic [DistW-1:0] sat_inc(input logic [DistW-1:0] v);
    if (v == DistMax) begin
      return DistMax;
    end
    return v + 1'b1;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/ned_if.sv]
// Valid/ready channel interfaces for the input beats and the result beats.
// Depends on ned_pkg for the field widths.
`default_nettype none

interface ned_in_if;
  import ned_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [CharW-1:0]  char_code;
  logic              last_char;

  modport source (output valid, output mode, output char_code, output last_char, input ready);
  modport sink   (input valid, input mode, input char_code, input last_char, output ready);
endinterface

interface ned_out_if;
  import ned_pkg::*;

  logic              valid;
  logic              ready;
  logic [DistW-1:0]  distance;
  logic [IndexW-1:0] candidate_index;
  logic              is_new_best;
  logic [IndexW-1:0] best_index;
  logic [DistW-1:0]  best_distance;
  logic              query_truncated;

  modport source (
    output valid, output distance, output candidate_index, output is_new_best,
    output best_index, output best_distance, output query_truncated, input ready
  );
  modport sink (
    input valid, input distance, input candidate_index, input is_new_best,
    input best_index, input best_distance, input query_truncated, output ready
  );
endinterface

`default_nettype wire

[hw/rtl/ned_ram.sv]
// Generic single write port, single read port RAM with a registered read.
// Depends on nothing.
`default_nettype none

module ned_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[hw/rtl/nearest_edit_distance_match.sv]
// Nearest match search by edit distance: a query is loaded, candidates stream in
// character by character, and each ended candidate yields its distance and the best so far.
// Depends on ned_pkg, ned_in_if, ned_out_if and ned_ram.
//
// A candidate character is applied to the edit distance column, which lives in a RAM
// and is read, updated and written back one entry per cycle, each entry needing the one
// before it; no new beat is accepted during the sweep. An ended candidate then loads the
// result register, waiting while that register still holds an untaken result; the
// register holds the result until it is taken while new beats are already accepted.
// After reset the block is ready at once: the first character of every candidate builds
// the starting column on the fly, so no RAM clearing pass is needed.
`default_nettype none

module nearest_edit_distance_match #(
  parameter int unsigned MAX_QUERY_LEN  = 32,
  parameter int unsigned MAX_CANDIDATES = 1024
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ned_in_if.sink     in_i,
  ned_out_if.source  out_o
);
  import ned_pkg::*;

  // Length counter, column index and query address widths, and the candidate index cap.
  localparam int unsigned LenW  = $clog2(MAX_QUERY_LEN + 1);
  localparam int unsigned QAddrW = (MAX_QUERY_LEN > 1) ? $clog2(MAX_QUERY_LEN) : 1;
  localparam int unsigned IdxCap =
      ((MAX_CANDIDATES - 1) > IndexMax) ? IndexMax : (MAX_CANDIDATES - 1);

  state_e state_q, state_d;

  logic [LenW-1:0]   len_q, len_d;
  logic              trunc_q, trunc_d;
  logic              fresh_q, fresh_d;
  logic [IndexW-1:0] cand_q, cand_d;
  logic              best_valid_q, best_valid_d;
  logic [IndexW-1:0] best_slot_q, best_slot_d;
  logic [DistW-1:0]  best_cost_q, best_cost_d;

  // Candidate character being applied to the column.
  logic [CharW-1:0]  ch_q, ch_d;
  logic              last_q, last_d;

  // Column sweep: issue index, compute stage and carried neighbors.
  logic [LenW:0]     iss_q, iss_d;
  logic              p_valid_q, p_valid_d;
  logic [LenW-1:0]   p_idx_q, p_idx_d;
  logic [DistW-1:0]  left_q, left_d;
  logic [DistW-1:0]  diag_q, diag_d;
  logic [DistW-1:0]  fin_dist_q, fin_dist_d;

  // Result register.
  logic              ov_q, ov_d;
  logic [DistW-1:0]  o_dist_q, o_dist_d;
  logic [IndexW-1:0] o_idx_q, o_idx_d;
  logic              o_new_q, o_new_d;
  logic [IndexW-1:0] o_bidx_q, o_bidx_d;
  logic [DistW-1:0]  o_bdist_q, o_bdist_d;
  logic              o_trunc_q, o_trunc_d;

  // RAM ports.
  logic              q_we;
  logic [QAddrW-1:0] q_waddr, q_raddr;
  logic [CharW-1:0]  q_wdata, q_rdata;
  logic              dp_we;
  logic [LenW-1:0]   dp_waddr, dp_raddr;
  logic [DistW-1:0]  dp_wdata, dp_rdata;

  logic              in_acc;
  logic [1:0]        mode_raw;
  logic [CharW-1:0]  in_ch;
  logic              issue;
  logic              done;
  logic              out_free;
  logic              better;

  // Column entry update.
  logic [DistW-1:0]  up_val, inc_up, inc_left, diag_sat, cur;
  logic [DistW:0]    diag_sum;

  assign mode_raw = in_i.mode;
  assign in_ch    = fold_char(in_i.char_code);
  assign in_acc   = in_i.valid && in_i.ready;
  assign issue    = (state_q == ST_RUN) && (iss_q <= {1'b0, len_q});
  assign done     = p_valid_q && (p_idx_q == len_q);
  assign out_free = !ov_q || out_o.ready;
  assign better   = !best_valid_q || (fin_dist_q < best_cost_q);

  // The first character of a candidate sees the starting column, entry i holding i.
  always_comb begin
    up_val   = fresh_q ? DistW'(p_idx_q) : dp_rdata;
    inc_up   = sat_inc(up_val);
    inc_left = sat_inc(left_q);
    diag_sum = {1'b0, diag_q} + {{DistW{1'b0}}, (q_rdata != ch_q)};
    diag_sat = diag_sum[DistW] ? DistMax : diag_sum[DistW-1:0];
    cur      = inc_up;
    if (p_idx_q != '0) begin
      if (inc_left < cur) begin
        cur = inc_left;
      end
      if (diag_sat < cur) begin
        cur = diag_sat;
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (mode_e'(mode_raw))
            MODE_CAND:  state_d = ST_RUN;
            MODE_EMPTY: state_d = ST_FIN;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_RUN: begin
        if (done) begin
          state_d = last_q ? ST_FIN : ST_IDLE;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Handshake and RAM controls.
  always_comb begin
    in_i.ready = (state_q == ST_IDLE);
    q_we       = in_acc && (mode_e'(mode_raw) == MODE_QUERY) && (len_q < LenW'(MAX_QUERY_LEN));
    q_waddr    = len_q[QAddrW-1:0];
    q_wdata    = in_ch;
    q_raddr    = QAddrW'(iss_q - 1'b1);
    dp_raddr   = (state_q == ST_RUN) ? iss_q[LenW-1:0] : '0;
    dp_we      = p_valid_q;
    dp_waddr   = p_idx_q;
    dp_wdata   = cur;
  end

  // Datapath and bookkeeping.
  always_comb begin
    len_d        = len_q;
    trunc_d      = trunc_q;
    fresh_d      = fresh_q;
    cand_d       = cand_q;
    best_valid_d = best_valid_q;
    best_slot_d  = best_slot_q;
    best_cost_d  = best_cost_q;
    ch_d         = ch_q;
    last_d       = last_q;
    iss_d        = iss_q;
    p_valid_d    = 1'b0;
    p_idx_d      = p_idx_q;
    left_d       = left_q;
    diag_d       = diag_q;
    fin_dist_d   = fin_dist_q;
    ov_d         = ov_q && !out_o.ready;
    o_dist_d     = o_dist_q;
    o_idx_d      = o_idx_q;
    o_new_d      = o_new_q;
    o_bidx_d     = o_bidx_q;
    o_bdist_d    = o_bdist_q;
    o_trunc_d    = o_trunc_q;

    // Accepted beats.
    if (in_acc) begin
      case (mode_e'(mode_raw))
        MODE_QUERY: begin
          fresh_d = 1'b1;
          if (len_q < LenW'(MAX_QUERY_LEN)) begin
            len_d = len_q + 1'b1;
          end else begin
            trunc_d = 1'b1;
          end
        end
        MODE_CAND: begin
          ch_d      = in_ch;
          last_d    = in_i.last_char;
          p_valid_d = 1'b1;
          p_idx_d   = '0;
          iss_d     = (LenW + 1)'(1);
        end
        MODE_EMPTY: begin
          fresh_d    = 1'b1;
          fin_dist_d = DistW'(len_q);
        end
        MODE_CLEAR: begin
          len_d        = '0;
          trunc_d      = 1'b0;
          cand_d       = '0;
          best_valid_d = 1'b0;
          best_slot_d  = '0;
          best_cost_d  = '0;
          fresh_d      = 1'b1;
        end
        default: begin
          fresh_d = fresh_q;
        end
      endcase
    end

    // Column sweep: issue the next read while the previous entry is updated.
    if (issue) begin
      p_valid_d = 1'b1;
      p_idx_d   = iss_q[LenW-1:0];
      iss_d     = iss_q + 1'b1;
    end
    if (p_valid_q) begin
      left_d = cur;
      diag_d = up_val;
    end
    if (done) begin
      fresh_d    = 1'b0;
      fin_dist_d = cur;
    end

    // Ended candidate: update the best match and load the result register.
    if ((state_q == ST_FIN) && out_free) begin
      ov_d      = 1'b1;
      o_dist_d  = fin_dist_q;
      o_idx_d   = cand_q;
      o_new_d   = better;
      o_bidx_d  = better ? cand_q : best_slot_q;
      o_bdist_d = better ? fin_dist_q : best_cost_q;
      o_trunc_d = trunc_q;
      fresh_d   = 1'b1;
      if (better) begin
        best_valid_d = 1'b1;
        best_slot_d  = cand_q;
        best_cost_d  = fin_dist_q;
      end
      if (cand_q < IndexW'(IdxCap)) begin
        cand_d = cand_q + 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      len_q        <= '0;
      trunc_q      <= 1'b0;
      fresh_q      <= 1'b1;
      cand_q       <= '0;
      best_valid_q <= 1'b0;
      best_slot_q  <= '0;
      best_cost_q  <= '0;
      iss_q        <= '0;
      p_valid_q    <= 1'b0;
      ov_q         <= 1'b0;
    end else begin
      state_q      <= state_d;
      len_q        <= len_d;
      trunc_q      <= trunc_d;
      fresh_q      <= fresh_d;
      cand_q       <= cand_d;
      best_valid_q <= best_valid_d;
      best_slot_q  <= best_slot_d;
      best_cost_q  <= best_cost_d;
      iss_q        <= iss_d;
      p_valid_q    <= p_valid_d;
      ov_q         <= ov_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    ch_q       <= ch_d;
    last_q     <= last_d;
    p_idx_q    <= p_idx_d;
    left_q     <= left_d;
    diag_q     <= diag_d;
    fin_dist_q <= fin_dist_d;
    o_dist_q   <= o_dist_d;
    o_idx_q    <= o_idx_d;
    o_new_q    <= o_new_d;
    o_bidx_q   <= o_bidx_d;
    o_bdist_q  <= o_bdist_d;
    o_trunc_q  <= o_trunc_d;
  end

  // Result channel.
  assign out_o.valid           = ov_q;
  assign out_o.distance        = o_dist_q;
  assign out_o.candidate_index = o_idx_q;
  assign out_o.is_new_best     = o_new_q;
  assign out_o.best_index      = o_bidx_q;
  assign out_o.best_distance   = o_bdist_q;
  assign out_o.query_truncated = o_trunc_q;

  // Query characters.
  ned_ram #(
    .Width (CharW),
    .Depth (MAX_QUERY_LEN)
  ) u_query_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  // Distance column.
  ned_ram #(
    .Width (DistW),
    .Depth (MAX_QUERY_LEN + 1)
  ) u_column_ram (
    .clk_i   (clk_i),
    .we_i    (dp_we),
    .waddr_i (dp_waddr),
    .wdata_i (dp_wdata),
    .raddr_i (dp_raddr),
    .rdata_o (dp_rdata)
  );

  // A new best result reports itself as the best match.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.is_new_best) |->
      ((out_o.best_distance == out_o.distance) && (out_o.best_index == out_o.candidate_index)))
    else $error("new best result does not match its own distance and index");

  // A result that is not a new best never beats the reported best.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.is_new_best) |-> (out_o.best_distance <= out_o.distance))
    else $error("result is closer than the reported best match");

  // The sweep never updates an entry past the end of the query.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_valid_q |-> (p_idx_q <= len_q))
    else $error("column update beyond the query length");

  // Consecutive column updates walk the entries in order.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p_valid_q && !done) |=> (p_valid_q && (p_idx_q == $past(p_idx_q) + 1'b1)))
    else $error("column sweep skipped or repeated an entry");

  // The candidate counter stops at its cap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cand_q <= IndexW'(IdxCap))
    else $error("candidate counter passed its cap");

endmodule

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for nearest_edit_distance_match: drives query, candidate, empty and clear beats
// and checks every result beat against an edit distance predictor kept in step with the block.
// Depends on ned_pkg, the ned_in_if / ned_out_if interfaces and the block's RTL.

module tb_top;
  import ned_pkg::*;

  localparam int unsigned QUERY_CAP    = 32;
  localparam int unsigned INDEX_CAP    = 1023;
  localparam int unsigned RANDOM_BEATS = 120;
  localparam int unsigned QUIET_BEATS  = 40;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned SHOW_LIMIT   = 10;

  // One result beat as the block reports it.
  typedef struct packed {
    logic [DistW-1:0]  distance;
    logic [IndexW-1:0] cand_idx;
    logic              new_best;
    logic [IndexW-1:0] best_idx;
    logic [DistW-1:0]  best_dist;
    logic              truncated;
  } match_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ned_in_if  in_if ();
  ned_out_if out_if ();

  nearest_edit_distance_match dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Predictor state: folded query, distance column and the running best match.
  logic [7:0]  qry [QUERY_CAP];
  int unsigned qry_len;
  logic [7:0]  col [QUERY_CAP+1];
  bit          col_fresh;
  int unsigned cand_next;
  bit          best_ok;
  int unsigned best_pos;
  int unsigned best_val;
  bit          qry_trunc;

  match_t      pending_matches[$];
  int unsigned mismatches;
  int unsigned beats_sent;
  int unsigned cycle_cnt;
  bit          src_idle;
  bit          sink_idle;
  bit          vld_hi;

  // Free running clock, 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Folding of ASCII upper case letters, as the block compares characters.
  function automatic logic [7:0] lower(input logic [7:0] c);
    if ((c >= 8'h41) && (c <= 8'h5A)) begin
      return c + 8'h20;
    end
    return c;
  endfunction

  function automatic int unsigned bump(input int unsigned v);
    return (v >= 255) ? 255 : v + 1;
  endfunction

  // Randomly turns a lower case letter into its upper case form.
  function automatic logic [7:0] flip_case(input logic [7:0] c);
    if ((c >= 8'h61) && (c <= 8'h7A) && ($urandom_range(0, 1) == 1)) begin
      return c - 8'h20;
    end
    return c;
  endfunction

  // Mostly a small alphabet so that distances stay interesting, sometimes any byte.
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 5))
      0: return 8'($urandom_range(0, 255));
      1: return 8'(8'h41 + $urandom_range(0, 3));
      default: return 8'(8'h61 + $urandom_range(0, 3));
    endcase
  endfunction

  function automatic void forget_all();
    qry_len   = 0;
    col_fresh = 1'b1;
    cand_next = 0;
    best_ok   = 1'b0;
    best_pos  = 0;
    best_val  = 0;
    qry_trunc = 1'b0;
  endfunction

  // A candidate has ended: rank it and queue the result beat it must produce.
  function automatic void score_candidate(input int unsigned d);
    match_t r;
    bit     better;
    better = !best_ok || (d < best_val);
    if (better) begin
      best_ok  = 1'b1;
      best_pos = cand_next;
      best_val = d;
    end
    r.distance  = 8'(d);
    r.cand_idx  = 10'(cand_next);
    r.new_best  = better;
    r.best_idx  = 10'(best_pos);
    r.best_dist = 8'(best_val);
    r.truncated = qry_trunc;
    pending_matches.push_back(r);
    if (cand_next < INDEX_CAP) begin
      cand_next++;
    end
    col_fresh = 1'b1;
  endfunction

  // Advances the edit distance state by one accepted input beat.
  function automatic void edit_distance_step(input mode_e m, input logic [7:0] raw,
                                             input logic last_c);
    logic [7:0]  ch;
    int unsigned diag, up, cur, alt, k;
    ch = lower(raw);
    case (m)
      MODE_QUERY: begin
        col_fresh = 1'b1;
        if (qry_len < QUERY_CAP) begin
          qry[qry_len] = ch;
          qry_len++;
        end else begin
          qry_trunc = 1'b1;
        end
      end
      MODE_CAND: begin
        if (col_fresh) begin
          for (k = 0; k <= qry_len; k++) begin
            col[k] = 8'(k);
          end
          col_fresh = 1'b0;
        end
        diag   = col[0];
        col[0] = 8'(bump(col[0]));
        for (k = 1; k <= qry_len; k++) begin
          up  = col[k];
          cur = bump(up);
          alt = bump(col[k-1]);
          if (alt < cur) begin
            cur = alt;
          end
          alt = diag + ((qry[k-1] != ch) ? 1 : 0);
          if (alt > 255) begin
            alt = 255;
          end
          if (alt < cur) begin
            cur = alt;
          end
          diag   = up;
          col[k] = 8'(cur);
        end
        if (last_c) begin
          score_candidate(col[qry_len]);
        end
      end
      MODE_EMPTY: begin
        score_candidate(qry_len);
      end
      default: begin
        forget_all();
      end
    endcase
  endfunction

  // Sends one beat, with an occasional random gap before it, and predicts its effect.
  task automatic send_beat(input mode_e m, input logic [7:0] c, input logic l);
    int unsigned gap;
    if (src_idle && ($urandom_range(0, 4) == 0)) begin
      gap = $urandom_range(1, 18);
      if (vld_hi) begin
        in_if.valid <= 1'b0;
        vld_hi = 1'b0;
      end
      repeat (gap) @(posedge clk_i);
    end
    if (!vld_hi) begin
      in_if.valid <= 1'b1;
      vld_hi = 1'b1;
    end
    in_if.mode      <= m;
    in_if.char_code <= c;
    in_if.last_char <= l;
    do @(posedge clk_i); while (!in_if.ready);
    edit_distance_step(m, c, l);
    beats_sent++;
  endtask

  // Sends a string as query characters or as one candidate.
  task automatic send_text(input string s, input mode_e m, input bit closes);
    int k;
    for (k = 0; k < s.len(); k++) begin
      send_beat(m, s[k], closes && (k == s.len() - 1));
    end
  endtask

  // Holds the sender off until every predicted result beat has been taken.
  task automatic pause_until_drained();
    if (vld_hi) begin
      in_if.valid <= 1'b0;
      vld_hi = 1'b0;
    end
    while (pending_matches.size() != 0) @(posedge clk_i);
  endtask

  // Classic small cases, every beat kind and the edge characters.
  task automatic test_directed();
    send_beat(MODE_CLEAR, 8'hFF, 1'b1);
    send_text("CaT", MODE_QUERY, 1'b0);
    send_text("cut", MODE_CAND, 1'b1);
    send_beat(MODE_EMPTY, 8'h00, 1'b0);
    // A partial candidate cut short by an empty candidate.
    send_text("ca", MODE_CAND, 1'b0);
    send_beat(MODE_EMPTY, 8'hAA, 1'b1);
    send_text("CAT", MODE_CAND, 1'b1);
    // A query character in the middle of a candidate discards it.
    send_beat(MODE_CAND, 8'h78, 1'b0);
    send_beat(MODE_QUERY, 8'hFF, 1'b0);
    send_text("@[Z", MODE_CAND, 1'b1);
    send_beat(MODE_CLEAR, 8'h00, 1'b0);
    send_beat(MODE_CAND, 8'h00, 1'b1);
    pause_until_drained();
  endtask

  // Overlong query and a candidate long enough to saturate every distance.
  task automatic test_long_candidate();
    int unsigned k;
    send_beat(MODE_CLEAR, 8'($urandom), 1'($urandom));
    for (k = 0; k < QUERY_CAP + 3; k++) begin
      send_beat(MODE_QUERY, flip_case(8'(8'h61 + $urandom_range(0, 2))), 1'($urandom));
    end
    for (k = 0; k < 290; k++) begin
      send_beat(MODE_CAND, flip_case(8'(8'h61 + $urandom_range(0, 2))), k == 289);
    end
    send_text("abc", MODE_CAND, 1'b1);
    // Clear drops the overflow flag again.
    send_beat(MODE_CLEAR, 8'($urandom), 1'($urandom));
    send_beat(MODE_EMPTY, 8'($urandom), 1'($urandom));
  endtask

  // Enough candidates without a clear to pin the index at its cap.
  task automatic test_index_saturation();
    int unsigned k;
    send_beat(MODE_CLEAR, 8'($urandom), 1'($urandom));
    send_text("ab", MODE_QUERY, 1'b0);
    for (k = 0; k < INDEX_CAP + 8; k++) begin
      if (k == 400) begin
        send_text("a", MODE_CAND, 1'b1);
      end else if (k == INDEX_CAP + 3) begin
        // An exact match once the index has stopped counting.
        send_text("AB", MODE_CAND, 1'b1);
      end else begin
        send_beat(MODE_EMPTY, 8'($urandom), 1'($urandom));
      end
    end
  endtask

  // Mostly well formed queries and candidates, with clears, stray beats and cut candidates.
  task automatic test_random_traffic();
    int unsigned start, n, k, pick, len, pause_at;
    logic [7:0]  c;
    start    = beats_sent;
    pause_at = 60;
    while (beats_sent - start < RANDOM_BEATS) begin
      n = beats_sent - start;
      if (n >= RANDOM_BEATS - QUIET_BEATS) begin
        src_idle  = 1'b0;
        sink_idle = 1'b0;
      end else if ($urandom_range(0, 39) == 0) begin
        src_idle  = 1'($urandom);
        sink_idle = 1'($urandom);
      end
      if (n >= pause_at) begin
        pause_until_drained();
        pause_at += 400;
      end
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        send_beat(MODE_CLEAR, 8'($urandom), 1'($urandom));
      end else if (pick < 15) begin
        // Fresh query, sometimes empty, sometimes past the bound.
        case ($urandom_range(0, 9))
          0: len = 0;
          1: len = $urandom_range(QUERY_CAP - 2, QUERY_CAP + 4);
          default: len = $urandom_range(1, 10);
        endcase
        send_beat(MODE_CLEAR, 8'($urandom), 1'($urandom));
        for (k = 0; k < len; k++) begin
          send_beat(MODE_QUERY, pick_char(), 1'($urandom));
        end
      end else if (pick < 20) begin
        send_beat(MODE_QUERY, pick_char(), 1'($urandom));
      end else if (pick < 28) begin
        send_beat(MODE_EMPTY, 8'($urandom), 1'($urandom));
      end else begin
        // Candidates that resemble the query; a few are left unfinished.
        if (pick < 33) begin
          len = $urandom_range(1, 4);
        end else if ($urandom_range(0, 19) == 0) begin
          len = $urandom_range(11, 40);
        end else begin
          len = $urandom_range(1, 10);
        end
        for (k = 0; k < len; k++) begin
          if ((k < qry_len) && ($urandom_range(0, 3) != 0)) begin
            c = flip_case(qry[k]);
          end else begin
            c = pick_char();
          end
          send_beat(MODE_CAND, c, (pick >= 33) && (k == len - 1));
        end
      end
    end
  endtask

  // Compares one taken result beat with the oldest prediction.
  task automatic check_match();
    match_t got, want;
    got.distance  = out_if.distance;
    got.cand_idx  = out_if.candidate_index;
    got.new_best  = out_if.is_new_best;
    got.best_idx  = out_if.best_index;
    got.best_dist = out_if.best_distance;
    got.truncated = out_if.query_truncated;
    if (pending_matches.size() == 0) begin
      mismatches++;
      if (mismatches <= SHOW_LIMIT) begin
        $display("cycle %0d: result beat with none pending: dist %0d idx %0d", cycle_cnt,
                 got.distance, got.cand_idx);
      end
    end else begin
      want = pending_matches.pop_front();
      if ((got.distance !== want.distance) || (got.cand_idx !== want.cand_idx) ||
          (got.new_best !== want.new_best) || (got.best_idx !== want.best_idx) ||
          (got.best_dist !== want.best_dist) || (got.truncated !== want.truncated)) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT) begin
          $display("cycle %0d: expected dist %0d idx %0d new %0b best %0d/%0d trunc %0b",
                   cycle_cnt, want.distance, want.cand_idx, want.new_best, want.best_idx,
                   want.best_dist, want.truncated);
          $display("cycle %0d:   actual dist %0d idx %0d new %0b best %0d/%0d trunc %0b",
                   cycle_cnt, got.distance, got.cand_idx, got.new_best, got.best_idx,
                   got.best_dist, got.truncated);
        end
      end
    end
  endtask

  // Every taken result beat is checked.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      check_match();
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side back pressure in random bursts while sink_idle is set.
  initial begin : sink_pacing
    int unsigned n;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      n = $urandom_range(1, 18);
      if (sink_idle && ($urandom_range(0, 2) == 0)) begin
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
      repeat (n - 1) @(posedge clk_i);
    end
  end

  // Test sequence.
  initial begin
    in_if.valid     <= 1'b0;
    in_if.mode      <= MODE_QUERY;
    in_if.char_code <= 8'h00;
    in_if.last_char <= 1'b0;
    cycle_cnt  = 0;
    mismatches = 0;
    beats_sent = 0;
    vld_hi     = 1'b0;
    src_idle   = 1'b1;
    sink_idle  = 1'b1;
    forget_all();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_long_candidate();
    test_index_saturation();
    test_random_traffic();

    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_matches.size() != 0) begin
      mismatches++;
      $display("%0d predicted result beats never arrived", pending_matches.size());
    end
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/ned_pkg.sv
hw/rtl/ned_if.sv
hw/rtl/ned_ram.sv
hw/rtl/nearest_edit_distance_match.sv
verif/tb_top.sv
